FILE: rtl/lhs_pkg.sv
// Shared types and constants of the latency histogram statistics block.
// Used by the controller, the datapath and the top level; no dependencies.
package lhs_pkg;

	localparam logic [30:0] TIME_MAX   = 31'h7FFF_FFFF;
	localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;
	localparam logic [31:0] TGT_DIV    = 32'd100000;
	localparam logic [31:0] TGT_HALF   = 32'd50000;
	localparam logic [10:0] BIU_RESET  = 11'd1024;
	localparam int          IN_TDATA_W = 64;
	localparam int          OUT_TDATA_W = 224;

	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_CLEAR = 2'd1,
		MODE_PCT   = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ADDR_CLR  = 2'd0,
		ADDR_BKT  = 2'd1,
		ADDR_WALK = 2'd2,
		ADDR_IDX  = 2'd3
	} addr_sel_t;

	typedef struct packed {
		logic      load;
		logic      stats_clr;
		logic      stats_upd;
		logic      bkt_ld;
		logic      div_start;
		logic      avg_ld;
		logic      tgt_mul;
		logic      walk_init;
		logic      walk_acc;
		logic      ram_en;
		logic      ram_we;
		logic      ram_clr;
		addr_sel_t addr_sel;
		logic      clr_inc;
		logic      res_ld;
	} lhs_cmd_t;

	typedef struct packed {
		logic div_done;
		logic div_busy;
		logic in_range;
		logic walk_more;
		logic clr_last;
	} lhs_sts_t;

endpackage

FILE: rtl/lhs_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module lhs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end
endmodule

FILE: rtl/lhs_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// No dependencies.
module lhs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic [63:0] quotient,
	output logic        busy,
	output logic        done
);
	logic [63:0] dvd_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] rem_sh;
	logic        ge;
	logic [32:0] rem_nx;

	assign rem_sh = {rem_q, dvd_q[63]};
	assign ge     = rem_sh >= {1'b0, dvs_q};
	assign rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[62:0], ge};
			rem_q <= rem_nx[31:0];
		end
	end

	assign quotient = dvd_q;
	assign busy     = busy_q;
	assign done     = done_q;
endmodule

FILE: rtl/lhs_dp.sv
// Datapath: statistics registers, bucket store, average divider, percentile walk.
// Depends on lhs_pkg, lhs_ram and lhs_div.
module lhs_dp #(
	parameter int MAX_BUCKETS     = 1024,
	parameter int BUCKET_WIDTH_NS = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lhs_pkg::lhs_cmd_t                    cmd,
	output lhs_pkg::lhs_sts_t                    sts,
	input  logic [lhs_pkg::IN_TDATA_W-1:0]       s_tdata,
	input  logic [1:0]                           s_tuser,
	input  logic                                 cfg_we,
	input  logic [10:0]                          cfg_data,
	output logic [lhs_pkg::OUT_TDATA_W-1:0]      m_tdata
);
	import lhs_pkg::*;

	localparam int          AW   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam logic [31:0] MAXB = 32'(MAX_BUCKETS);
	localparam logic [31:0] BW   = 32'(BUCKET_WIDTH_NS);
	localparam int          RSH  = 31 + $clog2(BUCKET_WIDTH_NS);
	localparam logic [63:0] RECIP64 = ((64'd1 << RSH) + 64'(BUCKET_WIDTH_NS) - 64'd1) /
		64'(BUCKET_WIDTH_NS);
	localparam logic [31:0] RECIP = RECIP64[31:0];

	mode_t       mode_q;
	logic [30:0] sample_q;
	logic [16:0] pm_q;
	logic [9:0]  idx_q;
	logic [10:0] biu_q;

	logic [30:0] min_q;
	logic [30:0] max_q;
	logic [63:0] total_q;
	logic [31:0] samples_q;
	logic [31:0] ovf_q;
	logic [30:0] avg_q;

	logic [31:0] bkt_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [AW:0] wi_q;
	logic [30:0] bound_q;
	logic [AW-1:0] clr_q;

	logic [31:0] act;
	logic [62:0] bprod;
	logic [63:0] quo;
	logic        div_busy;
	logic        div_done;
	logic [AW-1:0] ram_addr;
	logic [31:0] ram_wdata;
	logic [31:0] ram_rdata;
	logic [31:0] idx32;
	logic [64:0] total_sum;
	logic [48:0] mul;
	logic [48:0] scaled;
	logic [31:0] bsum;
	logic        idx_ok;
	logic        found;
	logic [30:0] bound_out;
	logic [31:0] bval_out;

	assign act    = (32'(biu_q) > MAXB) ? MAXB : 32'(biu_q);
	assign idx32  = 32'(idx_q);
	assign idx_ok = idx32 < MAXB;

	lhs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (total_q),
		.divisor  (samples_q),
		.quotient (quo),
		.busy     (div_busy),
		.done     (div_done)
	);

	always_comb begin
		unique case (cmd.addr_sel)
			ADDR_CLR:  ram_addr = clr_q;
			ADDR_BKT:  ram_addr = bkt_q[AW-1:0];
			ADDR_WALK: ram_addr = wi_q[AW-1:0];
			ADDR_IDX:  ram_addr = idx32[AW-1:0];
			default:   ram_addr = clr_q;
		endcase
	end

	assign ram_wdata = cmd.ram_clr ? 32'd0 :
		((ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 32'd1);

	lhs_ram #(
		.WIDTH (32),
		.DEPTH (MAX_BUCKETS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.en    (cmd.ram_en),
		.we    (cmd.ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign bprod     = sample_q * RECIP;
	assign total_sum = {1'b0, total_q} + 65'(sample_q);
	assign mul       = pm_q * samples_q;
	assign scaled    = ram_rdata * TGT_DIV[16:0];
	assign bsum      = 32'(bound_q) + BW;

	assign sts.div_done  = div_done;
	assign sts.div_busy  = div_busy;
	assign sts.in_range  = bkt_q < act;
	assign sts.walk_more = (32'(wi_q) < act) && (acc_q <= prod_q);
	assign sts.clr_last  = clr_q == AW'(MAX_BUCKETS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			biu_q     <= BIU_RESET;
			min_q     <= TIME_MAX;
			max_q     <= '0;
			total_q   <= '0;
			samples_q <= '0;
			ovf_q     <= '0;
			avg_q     <= '0;
			clr_q     <= '0;
		end else begin
			if (cfg_we) begin
				biu_q <= cfg_data;
			end
			if (cmd.stats_clr) begin
				min_q     <= TIME_MAX;
				max_q     <= '0;
				total_q   <= '0;
				samples_q <= '0;
				ovf_q     <= '0;
				avg_q     <= '0;
				clr_q     <= '0;
			end else begin
				if (cmd.clr_inc) begin
					clr_q <= sts.clr_last ? '0 : clr_q + AW'(1);
				end
				if (cmd.stats_upd) begin
					if (sample_q < min_q) begin
						min_q <= sample_q;
					end
					if (sample_q > max_q) begin
						max_q <= sample_q;
					end
					total_q <= total_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : total_sum[63:0];
					if (samples_q != COUNT_MAX) begin
						samples_q <= samples_q + 32'd1;
					end
					if (!sts.in_range && ovf_q != COUNT_MAX) begin
						ovf_q <= ovf_q + 32'd1;
					end
				end
				if (cmd.avg_ld) begin
					avg_q <= (quo > 64'(TIME_MAX)) ? TIME_MAX : quo[30:0];
				end
			end
		end
	end

	// walk keeps (sum + 1) * 100000 and compares it with percent_milli * samples + 50000
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= mode_t'(s_tuser);
			sample_q <= s_tdata[30:0];
			pm_q     <= s_tdata[47:31];
			idx_q    <= s_tdata[57:48];
		end
		if (cmd.bkt_ld) begin
			bkt_q <= 32'(bprod >> RSH);
		end
		if (cmd.tgt_mul) begin
			prod_q <= 64'(mul) + 64'(TGT_HALF);
		end
		if (cmd.walk_init) begin
			acc_q   <= 64'(TGT_DIV);
			wi_q    <= '0;
			bound_q <= '0;
		end else if (cmd.walk_acc) begin
			acc_q   <= acc_q + 64'(scaled);
			wi_q    <= wi_q + (AW+1)'(1);
			bound_q <= (bsum > 32'(TIME_MAX)) ? TIME_MAX : bsum[30:0];
		end
		if (cmd.res_ld) begin
			m_tdata <= {3'b000, bval_out, bound_out, found, samples_q, ovf_q,
				avg_q, max_q, min_q};
		end
	end

	assign found     = (mode_q == MODE_PCT) && (acc_q > prod_q);
	assign bound_out = (mode_q == MODE_PCT) ? bound_q : '0;
	assign bval_out  = (mode_q == MODE_READ && idx_ok) ? ram_rdata : '0;

`ifndef SYNTHESIS
	a_wi_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_acc |-> (32'(wi_q) < act))
		else $error("walk stepped past the buckets in use");
	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		(samples_q != 32'd0) |-> (min_q <= max_q))
		else $error("minimum above maximum with samples present");
`endif
endmodule

FILE: rtl/lhs_ctrl.sv
// Controller state machine: sequences each word through the datapath.
// Depends on lhs_pkg.
module lhs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [1:0]        s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	output lhs_pkg::lhs_cmd_t cmd,
	input  lhs_pkg::lhs_sts_t sts
);
	import lhs_pkg::*;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_A_START, S_A_CHK, S_A_RD, S_A_WR, S_A_UPD,
		S_V_START, S_V_WAIT, S_T_MUL, S_W_CHK, S_W_RD,
		S_W_ACC, S_R_RD, S_OUT
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   pend_q;
	logic   m_tvalid_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_CLR: begin
				cmd.ram_en   = 1'b1;
				cmd.ram_we   = 1'b1;
				cmd.ram_clr  = 1'b1;
				cmd.addr_sel = ADDR_CLR;
				cmd.clr_inc  = 1'b1;
				if (sts.clr_last) begin
					state_nx = pend_q ? S_OUT : S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					unique case (mode_t'(s_tuser))
						MODE_ADD:   state_nx = S_A_START;
						MODE_CLEAR: begin
							cmd.stats_clr = 1'b1;
							state_nx      = S_CLR;
						end
						MODE_PCT:   state_nx = S_T_MUL;
						MODE_READ:  state_nx = S_R_RD;
						default:    state_nx = S_IDLE;
					endcase
				end
			end
			S_A_START: begin
				cmd.bkt_ld = 1'b1;
				state_nx   = S_A_CHK;
			end
			S_A_CHK: state_nx = sts.in_range ? S_A_RD : S_A_UPD;
			S_A_RD: begin
				cmd.ram_en   = 1'b1;
				cmd.addr_sel = ADDR_BKT;
				state_nx     = S_A_WR;
			end
			S_A_WR: begin
				cmd.ram_en   = 1'b1;
				cmd.ram_we   = 1'b1;
				cmd.addr_sel = ADDR_BKT;
				state_nx     = S_A_UPD;
			end
			S_A_UPD: begin
				cmd.stats_upd = 1'b1;
				state_nx      = S_V_START;
			end
			S_V_START: begin
				cmd.div_start = 1'b1;
				state_nx      = S_V_WAIT;
			end
			S_V_WAIT: begin
				if (sts.div_done) begin
					cmd.avg_ld = 1'b1;
					state_nx   = S_OUT;
				end
			end
			S_T_MUL: begin
				cmd.tgt_mul   = 1'b1;
				cmd.walk_init = 1'b1;
				state_nx      = S_W_CHK;
			end
			S_W_CHK: state_nx = sts.walk_more ? S_W_RD : S_OUT;
			S_W_RD: begin
				cmd.ram_en   = 1'b1;
				cmd.addr_sel = ADDR_WALK;
				state_nx     = S_W_ACC;
			end
			S_W_ACC: begin
				cmd.walk_acc = 1'b1;
				state_nx     = S_W_CHK;
			end
			S_R_RD: begin
				cmd.ram_en   = 1'b1;
				cmd.addr_sel = ADDR_IDX;
				state_nx     = S_OUT;
			end
			S_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.res_ld = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			pend_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.stats_clr) begin
				pend_q <= 1'b1;
			end else if (state_q == S_CLR && sts.clr_last) begin
				pend_q <= 1'b0;
			end
			if (cmd.res_ld) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;

`ifndef SYNTHESIS
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider started while busy");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |-> !cmd.res_ld)
		else $error("result overwritten before it was taken");
`endif
endmodule

FILE: rtl/latency_histogram_stats_core.sv
// Top level of the latency histogram statistics block.
// Depends on lhs_pkg, lhs_ctrl and lhs_dp (with lhs_ram and lhs_div below it).
//
// One word in gives one word out. After reset the bucket store is swept to
// zero, one bucket a cycle, before the first word is taken; the configuration
// port is open throughout. Add sample finds the bucket index by a reciprocal
// multiply, does a read-modify-write of the bucket (skipped when the sample
// is an overflow) and then runs the 64-step average divider. Clear runs the
// same sweep. Percentile walks the buckets through the single RAM port. Read
// bucket does a single RAM read. A finished result waits in the output
// register while the next word is accepted.
module latency_histogram_stats_core #(
	parameter int MAX_BUCKETS     = 1024,
	parameter int BUCKET_WIDTH_NS = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// sample_ns[30:0], percent_milli[47:31], bucket_index[57:48], zero [63:58]
	input  logic [lhs_pkg::IN_TDATA_W-1:0]    s_tdata,
	// mode[1:0]
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// min_time[30:0], max_time[61:31], average_time[92:62],
	// overflow_count[124:93], sample_count[156:125], percentile_found[157],
	// percentile_bound_ns[188:158], bucket_value[220:189], zero [223:221]
	output logic [lhs_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [10:0]                       cfg_data
);
	import lhs_pkg::*;

	lhs_cmd_t cmd;
	lhs_sts_t sts;

	assign cfg_ready = 1'b1;

	lhs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	lhs_dp #(
		.MAX_BUCKETS     (MAX_BUCKETS),
		.BUCKET_WIDTH_NS (BUCKET_WIDTH_NS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.m_tdata  (m_tdata)
	);
endmodule
